FILE: sv/datestamp_to_calendar_top_macros.svh
// ---------------------------------------------------------------------------
// Assertion macros for datestamp_to_calendar_top
// Shared clocked implication checks with asynchronous reset disable.
// ---------------------------------------------------------------------------
`ifndef DATESTAMP_TO_CALENDAR_TOP_MACROS_SVH
`define DATESTAMP_TO_CALENDAR_TOP_MACROS_SVH

// same-cycle implication
`define DTC_ASSERT_NOW(lbl, ck, rst_n, ante, cons) \
	lbl: assert property (@(posedge ck) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("datestamp_to_calendar check failed");

// next-cycle implication
`define DTC_ASSERT_NEXT(lbl, ck, rst_n, ante, cons) \
	lbl: assert property (@(posedge ck) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("datestamp_to_calendar check failed");

`endif

FILE: sv/dtc_pkg.sv
// ---------------------------------------------------------------------------
// dtc_pkg
// Widths, calendar constants and reciprocal divider constants.
// ---------------------------------------------------------------------------
package dtc_pkg;

	localparam int DAY_COUNT_BITS = 16;

	localparam int MIN_W    = 11;
	localparam int TICK_W   = 12;
	localparam int YEAR_W   = 12;
	localparam int MONTH_W  = 4;
	localparam int DOM_W    = 5;
	localparam int DOY_W    = 9;
	localparam int WDAY_W   = 3;
	localparam int HOUR_W   = 5;
	localparam int MINUTE_W = 6;
	localparam int SECOND_W = 6;
	localparam int MP_W     = 4;
	localparam int DOE_W    = 18;
	localparam int YOE_W    = 9;

	localparam int MINUTES_PER_DAY  = 1440;
	localparam int TICKS_PER_MINUTE = 3000;
	localparam int MINUTES_PER_HOUR = 60;
	localparam int TICKS_PER_SECOND = 50;
	localparam int DAYS_PER_WEEK    = 7;
	localparam int MONTHS           = 12;

	// days from 1 March of year 0 to 1 January 1978
	localparam int EPOCH_OFS  = 722390;
	localparam int ERA_DAYS   = 146097;
	localparam int CENT_DAYS  = 36524;
	localparam int QUAD_DAYS  = 1460;
	localparam int YEAR_DAYS  = 365;
	localparam int ERA_YEARS  = 400;
	localparam int CENT_YEARS = 100;
	// March-based index of January
	localparam int MP_JAN     = 10;

	localparam int ZW    = $clog2((64'd1 << DAY_COUNT_BITS) + EPOCH_OFS);
	localparam int ERA_W = $clog2(((64'd1 << ZW) - 1) / ERA_DAYS + 1);
	localparam int YR_W  = $clog2((64'd1 << ERA_W) * ERA_YEARS + 1);

	// floor(x / D) == (x * R) >> K for every x below 2**N when 2**K >= D * 2**N
	localparam int     WD_K  = $clog2((64'd1 << DAY_COUNT_BITS) * DAYS_PER_WEEK);
	localparam longint WD_R  = ((64'd1 << WD_K) + DAYS_PER_WEEK - 1) / DAYS_PER_WEEK;
	localparam int     WD_RW = $clog2(WD_R + 1);
	localparam int     WD_PW = DAY_COUNT_BITS + WD_RW;

	localparam int     HR_K  = $clog2((64'd1 << MIN_W) * MINUTES_PER_HOUR);
	localparam longint HR_R  = ((64'd1 << HR_K) + MINUTES_PER_HOUR - 1) / MINUTES_PER_HOUR;
	localparam int     HR_RW = $clog2(HR_R + 1);
	localparam int     HR_PW = MIN_W + HR_RW;

	localparam int     SC_K  = $clog2((64'd1 << TICK_W) * TICKS_PER_SECOND);
	localparam longint SC_R  = ((64'd1 << SC_K) + TICKS_PER_SECOND - 1) / TICKS_PER_SECOND;
	localparam int     SC_RW = $clog2(SC_R + 1);
	localparam int     SC_PW = TICK_W + SC_RW;

	localparam int     ERA_K  = $clog2((64'd1 << ZW) * ERA_DAYS);
	localparam longint ERA_R  = ((64'd1 << ERA_K) + ERA_DAYS - 1) / ERA_DAYS;
	localparam int     ERA_RW = $clog2(ERA_R + 1);
	localparam int     ERA_PW = ZW + ERA_RW;

	localparam int     QD_K  = $clog2((64'd1 << DOE_W) * QUAD_DAYS);
	localparam longint QD_R  = ((64'd1 << QD_K) + QUAD_DAYS - 1) / QUAD_DAYS;
	localparam int     QD_RW = $clog2(QD_R + 1);
	localparam int     QD_PW = DOE_W + QD_RW;

	localparam int     YD_K  = $clog2((64'd1 << DOE_W) * YEAR_DAYS);
	localparam longint YD_R  = ((64'd1 << YD_K) + YEAR_DAYS - 1) / YEAR_DAYS;
	localparam int     YD_RW = $clog2(YD_R + 1);
	localparam int     YD_PW = DOE_W + YD_RW;

	typedef struct packed {
		logic [WDAY_W-1:0]   weekday;
		logic [HOUR_W-1:0]   hour;
		logic [MINUTE_W-1:0] minute;
		logic [SECOND_W-1:0] second;
		logic                bad;
	} side_t;

	// first day of each March-based month
	function automatic logic [DOY_W-1:0] month_start(input logic [MP_W-1:0] mp);
		logic [DOY_W-1:0] d;
		unique case (mp)
			4'd0:    d = 9'd0;
			4'd1:    d = 9'd31;
			4'd2:    d = 9'd61;
			4'd3:    d = 9'd92;
			4'd4:    d = 9'd122;
			4'd5:    d = 9'd153;
			4'd6:    d = 9'd184;
			4'd7:    d = 9'd214;
			4'd8:    d = 9'd245;
			4'd9:    d = 9'd275;
			4'd10:   d = 9'd306;
			4'd11:   d = 9'd337;
			default: d = 9'd0;
		endcase
		return d;
	endfunction

endpackage

FILE: sv/datestamp_to_calendar_top.sv
// ---------------------------------------------------------------------------
// datestamp_to_calendar_top
// Date stamp (days since 1 Jan 1978, minute, tick) to calendar date and time.
// ---------------------------------------------------------------------------
//  channel | handshake           | beat
//  input   | in_valid / in_stall | day_count, minute_of_day, tick_of_minute
//  output  | out_valid/out_stall | year, month, day_of_month, day_of_year,
//          |                     | weekday, hour, minute, second, bad_input
//
//  Nine register stages; one beat per cycle sustained while out_stall stays low.
//  The era divide, the 1460-day and 365-day reciprocal multiplies each own a stage.
//  Each stage holds only while it is full and the stage after it holds.
//  Reset clears the stage valid bits only.
// ---------------------------------------------------------------------------
module datestamp_to_calendar_top (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  in_valid,
	output logic                                  in_stall,
	input  logic [dtc_pkg::DAY_COUNT_BITS-1:0]    day_count,
	input  logic [dtc_pkg::MIN_W-1:0]             minute_of_day,
	input  logic [dtc_pkg::TICK_W-1:0]            tick_of_minute,
	output logic                                  out_valid,
	input  logic                                  out_stall,
	output logic [dtc_pkg::YEAR_W-1:0]            year,
	output logic [dtc_pkg::MONTH_W-1:0]           month,
	output logic [dtc_pkg::DOM_W-1:0]             day_of_month,
	output logic [dtc_pkg::DOY_W-1:0]             day_of_year,
	output logic [dtc_pkg::WDAY_W-1:0]            weekday,
	output logic [dtc_pkg::HOUR_W-1:0]            hour,
	output logic [dtc_pkg::MINUTE_W-1:0]          minute,
	output logic [dtc_pkg::SECOND_W-1:0]          second,
	output logic                                  bad_input
);

	logic v_s1, v_s2, v_s3, v_s4, v_s5, v_s6, v_s7, v_s8, v_s9;
	logic en_s1, en_s2, en_s3, en_s4, en_s5, en_s6, en_s7, en_s8, en_s9;

	logic [dtc_pkg::DAY_COUNT_BITS-1:0] days_s1;
	logic [dtc_pkg::ZW-1:0]             z_s1, z_s2;
	logic [dtc_pkg::WD_PW-1:0]          wd_p_s1;
	logic [dtc_pkg::HR_PW-1:0]          hr_p_s1;
	logic [dtc_pkg::SC_PW-1:0]          sc_p_s1;
	logic [dtc_pkg::MIN_W-1:0]          mins_s1;
	logic                               bad_min_s1, bad_tick_s1;

	logic [dtc_pkg::ERA_PW-1:0] era_p_s2;
	dtc_pkg::side_t side_s2, side_s3, side_s4, side_s5, side_s6, side_s7, side_s8, side_s9;

	logic [dtc_pkg::ERA_W-1:0] era_s3, era_s4, era_s5, era_s6, era_s7, era_s8;
	logic [dtc_pkg::DOE_W-1:0] doe_s3, doe_s4, doe_s5, doe_s6;
	logic [dtc_pkg::QD_PW-1:0] qd_p_s4;
	logic [2:0]                cent_s4;
	logic                      last_s4;
	logic [dtc_pkg::DOE_W-1:0] t_s5;
	logic [dtc_pkg::YD_PW-1:0] yr_p_s6;
	logic [dtc_pkg::YOE_W-1:0] yoe_s7, yoe_s8;
	logic [dtc_pkg::DOY_W-1:0] doy_s7, doy_s8;
	logic [dtc_pkg::MP_W-1:0]  mp_s8;
	logic                      leap_s8;

	logic [dtc_pkg::YEAR_W-1:0]  year_s9;
	logic [dtc_pkg::MONTH_W-1:0] month_s9;
	logic [dtc_pkg::DOM_W-1:0]   dom_s9;
	logic [dtc_pkg::DOY_W-1:0]   doy_s9;

	// stage handshakes
	assign en_s9    = !v_s9 || !out_stall;
	assign en_s8    = !v_s8 || en_s9;
	assign en_s7    = !v_s7 || en_s8;
	assign en_s6    = !v_s6 || en_s7;
	assign en_s5    = !v_s5 || en_s6;
	assign en_s4    = !v_s4 || en_s5;
	assign en_s3    = !v_s3 || en_s4;
	assign en_s2    = !v_s2 || en_s3;
	assign en_s1    = !v_s1 || en_s2;
	assign in_stall = !en_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
			v_s6 <= 1'b0;
			v_s7 <= 1'b0;
			v_s8 <= 1'b0;
			v_s9 <= 1'b0;
		end else begin
			if (en_s1) v_s1 <= in_valid;
			if (en_s2) v_s2 <= v_s1;
			if (en_s3) v_s3 <= v_s2;
			if (en_s4) v_s4 <= v_s3;
			if (en_s5) v_s5 <= v_s4;
			if (en_s6) v_s6 <= v_s5;
			if (en_s7) v_s7 <= v_s6;
			if (en_s8) v_s8 <= v_s7;
			if (en_s9) v_s9 <= v_s8;
		end
	end

	// stage 2 combinational
	logic [dtc_pkg::DAY_COUNT_BITS-1:0] wd_q, wd_rem;
	logic [dtc_pkg::MIN_W-1:0]          hour_full, minute_full;
	logic [dtc_pkg::TICK_W-1:0]         second_full;
	dtc_pkg::side_t                     side_d;

	always_comb begin
		wd_q        = dtc_pkg::DAY_COUNT_BITS'(wd_p_s1 >> dtc_pkg::WD_K);
		wd_rem      = days_s1 - wd_q * dtc_pkg::DAY_COUNT_BITS'(dtc_pkg::DAYS_PER_WEEK);
		hour_full   = dtc_pkg::MIN_W'(hr_p_s1 >> dtc_pkg::HR_K);
		minute_full = mins_s1 - hour_full * dtc_pkg::MIN_W'(dtc_pkg::MINUTES_PER_HOUR);
		second_full = dtc_pkg::TICK_W'(sc_p_s1 >> dtc_pkg::SC_K);
		side_d.weekday = wd_rem[dtc_pkg::WDAY_W-1:0];
		side_d.hour    = bad_min_s1 ? '0 : hour_full[dtc_pkg::HOUR_W-1:0];
		side_d.minute  = bad_min_s1 ? '0 : minute_full[dtc_pkg::MINUTE_W-1:0];
		side_d.second  = bad_tick_s1 ? '0 : second_full[dtc_pkg::SECOND_W-1:0];
		side_d.bad     = bad_min_s1 || bad_tick_s1;
	end

	// stage 3 combinational
	logic [dtc_pkg::ERA_W-1:0] era_d;
	logic [dtc_pkg::DOE_W-1:0] doe_d;

	always_comb begin
		era_d = dtc_pkg::ERA_W'(era_p_s2 >> dtc_pkg::ERA_K);
		doe_d = dtc_pkg::DOE_W'(z_s2 - dtc_pkg::ZW'(era_d) * dtc_pkg::ZW'(dtc_pkg::ERA_DAYS));
	end

	// stage 7 combinational
	logic [dtc_pkg::YOE_W-1:0] yoe_d;
	logic [1:0]                ycent_d;
	logic [dtc_pkg::DOE_W-1:0] ystart_d;

	always_comb begin
		yoe_d    = dtc_pkg::YOE_W'(yr_p_s6 >> dtc_pkg::YD_K);
		ycent_d  = 2'(yoe_d >= dtc_pkg::YOE_W'(dtc_pkg::CENT_YEARS))
			+ 2'(yoe_d >= dtc_pkg::YOE_W'(2 * dtc_pkg::CENT_YEARS))
			+ 2'(yoe_d >= dtc_pkg::YOE_W'(3 * dtc_pkg::CENT_YEARS));
		ystart_d = dtc_pkg::DOE_W'(yoe_d) * dtc_pkg::DOE_W'(dtc_pkg::YEAR_DAYS)
			+ dtc_pkg::DOE_W'(yoe_d[dtc_pkg::YOE_W-1:2]) - dtc_pkg::DOE_W'(ycent_d);
	end

	// stage 8 combinational
	logic [dtc_pkg::MP_W-1:0] mp_d;
	logic                     leap_d;

	always_comb begin
		mp_d = '0;
		for (int i = 1; i < dtc_pkg::MONTHS; i++) begin
			mp_d = mp_d + dtc_pkg::MP_W'(doy_s7 >= dtc_pkg::month_start(dtc_pkg::MP_W'(i)));
		end
		leap_d = (yoe_s7[1:0] == 2'd0)
			&& !(yoe_s7 == dtc_pkg::YOE_W'(dtc_pkg::CENT_YEARS)
			|| yoe_s7 == dtc_pkg::YOE_W'(2 * dtc_pkg::CENT_YEARS)
			|| yoe_s7 == dtc_pkg::YOE_W'(3 * dtc_pkg::CENT_YEARS));
	end

	// stage 9 combinational
	logic                       jan_feb;
	logic [dtc_pkg::DOY_W-1:0]  jan_start;
	logic [dtc_pkg::DOY_W-1:0]  dom_full;
	logic [dtc_pkg::YR_W-1:0]   year_full;

	always_comb begin
		jan_feb   = mp_s8 >= dtc_pkg::MP_W'(dtc_pkg::MP_JAN);
		jan_start = dtc_pkg::month_start(dtc_pkg::MP_W'(dtc_pkg::MP_JAN));
		dom_full  = doy_s8 - dtc_pkg::month_start(mp_s8) + dtc_pkg::DOY_W'(1);
		year_full = dtc_pkg::YR_W'(era_s8) * dtc_pkg::YR_W'(dtc_pkg::ERA_YEARS)
			+ dtc_pkg::YR_W'(yoe_s8) + dtc_pkg::YR_W'(jan_feb);
	end

	always_ff @(posedge clk) begin
		if (en_s1) begin
			days_s1     <= day_count;
			z_s1        <= dtc_pkg::ZW'(day_count) + dtc_pkg::ZW'(dtc_pkg::EPOCH_OFS);
			wd_p_s1     <= dtc_pkg::WD_PW'(day_count) * dtc_pkg::WD_PW'(dtc_pkg::WD_R);
			hr_p_s1     <= dtc_pkg::HR_PW'(minute_of_day) * dtc_pkg::HR_PW'(dtc_pkg::HR_R);
			sc_p_s1     <= dtc_pkg::SC_PW'(tick_of_minute) * dtc_pkg::SC_PW'(dtc_pkg::SC_R);
			mins_s1     <= minute_of_day;
			bad_min_s1  <= minute_of_day >= dtc_pkg::MIN_W'(dtc_pkg::MINUTES_PER_DAY);
			bad_tick_s1 <= tick_of_minute >= dtc_pkg::TICK_W'(dtc_pkg::TICKS_PER_MINUTE);
		end
		if (en_s2) begin
			era_p_s2 <= dtc_pkg::ERA_PW'(z_s1) * dtc_pkg::ERA_PW'(dtc_pkg::ERA_R);
			z_s2     <= z_s1;
			side_s2  <= side_d;
		end
		if (en_s3) begin
			era_s3  <= era_d;
			doe_s3  <= doe_d;
			side_s3 <= side_s2;
		end
		if (en_s4) begin
			qd_p_s4 <= dtc_pkg::QD_PW'(doe_s3) * dtc_pkg::QD_PW'(dtc_pkg::QD_R);
			cent_s4 <= 3'(doe_s3 >= dtc_pkg::DOE_W'(dtc_pkg::CENT_DAYS))
				+ 3'(doe_s3 >= dtc_pkg::DOE_W'(2 * dtc_pkg::CENT_DAYS))
				+ 3'(doe_s3 >= dtc_pkg::DOE_W'(3 * dtc_pkg::CENT_DAYS))
				+ 3'(doe_s3 >= dtc_pkg::DOE_W'(4 * dtc_pkg::CENT_DAYS));
			last_s4 <= doe_s3 == dtc_pkg::DOE_W'(dtc_pkg::ERA_DAYS - 1);
			doe_s4  <= doe_s3;
			era_s4  <= era_s3;
			side_s4 <= side_s3;
		end
		if (en_s5) begin
			t_s5    <= doe_s4 - dtc_pkg::DOE_W'(qd_p_s4 >> dtc_pkg::QD_K)
				+ dtc_pkg::DOE_W'(cent_s4) - dtc_pkg::DOE_W'(last_s4);
			doe_s5  <= doe_s4;
			era_s5  <= era_s4;
			side_s5 <= side_s4;
		end
		if (en_s6) begin
			yr_p_s6 <= dtc_pkg::YD_PW'(t_s5) * dtc_pkg::YD_PW'(dtc_pkg::YD_R);
			doe_s6  <= doe_s5;
			era_s6  <= era_s5;
			side_s6 <= side_s5;
		end
		if (en_s7) begin
			yoe_s7  <= yoe_d;
			doy_s7  <= dtc_pkg::DOY_W'(doe_s6 - ystart_d);
			era_s7  <= era_s6;
			side_s7 <= side_s6;
		end
		if (en_s8) begin
			mp_s8   <= mp_d;
			leap_s8 <= leap_d;
			yoe_s8  <= yoe_s7;
			doy_s8  <= doy_s7;
			era_s8  <= era_s7;
			side_s8 <= side_s7;
		end
		if (en_s9) begin
			year_s9  <= year_full[dtc_pkg::YEAR_W-1:0];
			month_s9 <= jan_feb ? mp_s8 - dtc_pkg::MP_W'(dtc_pkg::MP_JAN)
				: mp_s8 + dtc_pkg::MP_W'(dtc_pkg::MONTHS - dtc_pkg::MP_JAN);
			dom_s9   <= dom_full[dtc_pkg::DOM_W-1:0];
			doy_s9   <= jan_feb ? doy_s8 - jan_start
				: doy_s8 + (dtc_pkg::DOY_W'(dtc_pkg::YEAR_DAYS) - jan_start)
				+ dtc_pkg::DOY_W'(leap_s8);
			side_s9  <= side_s8;
		end
	end

	assign out_valid    = v_s9;
	assign year         = year_s9;
	assign month        = month_s9;
	assign day_of_month = dom_s9;
	assign day_of_year  = doy_s9;
	assign weekday      = side_s9.weekday;
	assign hour         = side_s9.hour;
	assign minute       = side_s9.minute;
	assign second       = side_s9.second;
	assign bad_input    = side_s9.bad;

endmodule

FILE: sv/dtc_checker.sv
// ---------------------------------------------------------------------------
// dtc_checker
// Port-level checks on the calendar converter, bound to the top level.
// ---------------------------------------------------------------------------
`include "datestamp_to_calendar_top_macros.svh"

module dtc_checker (
	input logic                          clk,
	input logic                          arst_n,
	input logic                          in_stall,
	input logic                          out_valid,
	input logic                          out_stall,
	input logic [dtc_pkg::YEAR_W-1:0]    year,
	input logic [dtc_pkg::MONTH_W-1:0]   month,
	input logic [dtc_pkg::DOM_W-1:0]     day_of_month,
	input logic [dtc_pkg::DOY_W-1:0]     day_of_year,
	input logic [dtc_pkg::WDAY_W-1:0]    weekday,
	input logic [dtc_pkg::HOUR_W-1:0]    hour,
	input logic [dtc_pkg::MINUTE_W-1:0]  minute,
	input logic [dtc_pkg::SECOND_W-1:0]  second,
	input logic                          bad_input
);

	`DTC_ASSERT_NEXT(a_out_valid_hold, clk, arst_n, out_valid && out_stall, out_valid)
	`DTC_ASSERT_NEXT(a_out_beat_hold, clk, arst_n, out_valid && out_stall, $stable(year) && $stable(month) && $stable(day_of_month) && $stable(day_of_year) && $stable(weekday) && $stable(hour) && $stable(minute) && $stable(second) && $stable(bad_input))
	`DTC_ASSERT_NOW(a_flow_when_drained, clk, arst_n, !out_stall, !in_stall)
	`DTC_ASSERT_NOW(a_flow_when_empty, clk, arst_n, !out_valid, !in_stall)

endmodule

bind datestamp_to_calendar_top dtc_checker u_dtc_checker (.*);
